>>> src/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/igs_pkg.sv
// package: shared constants, types and compare function of the group sorter
package igs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic insert;
        logic drain;
    } chain_ctrl_t;

    // signed less-than on two's complement words
    function automatic logic value_less(input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b);
        value_less = $signed(a) < $signed(b);
    endfunction

endpackage

>>> src/igs_cell.sv
// one cell of the insertion chain: holds one value and its valid bit
module igs_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  igs_pkg::chain_ctrl_t           ctrl,
    input  logic [igs_pkg::DATA_W-1:0]     new_val,
    input  logic [igs_pkg::DATA_W-1:0]     prev_val,
    input  logic                           prev_valid,
    input  logic                           prev_shift,
    input  logic [igs_pkg::DATA_W-1:0]     next_val,
    input  logic                           next_valid,
    output logic [igs_pkg::DATA_W-1:0]     val,
    output logic                           valid,
    output logic                           shift
);

    logic [igs_pkg::DATA_W-1:0] val_reg;
    logic [igs_pkg::DATA_W-1:0] val_next;
    logic                       valid_reg;
    logic                       valid_next;

    // empty cells count as larger than any value, equal values stay ahead
    assign shift = !valid_reg || igs_pkg::value_less(new_val, val_reg);

    // insert: displaced cells take the left neighbor, the first one takes the new value
    // drain: every cell takes its right neighbor
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.insert && shift)
        begin
            val_next   = prev_shift ? prev_val : new_val;
            valid_next = prev_shift ? prev_valid : 1'b1;
        end
        else if (ctrl.drain)
        begin
            val_next   = next_val;
            valid_next = next_valid;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // held value
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

>>> src/integer_group_sorter.sv
// top level: insertion-chain sorter for groups of signed integers
//
//  channel   ports                                   beat taken when
//  -------   -------------------------------------   ---------------------------
//  input     start, busy, value, group_end           start && !busy at clk rise
//  result    result_valid, sorted_value,             result_valid, one cycle each
//            final_res, overflow
//
//  each value is placed into the sorted chain by a broadcast compare, so a group
//  streams in at one value per clock while busy is low; the broadcast compare
//  sets that figure; on the group's last beat busy rises, and it stays high while
//  the chain shifts left and one result leaves per cycle, one per held value; the
//  first result is registered from the head cell once the state has entered drain
//  a new group may start while the final result shows
//  rst_n clears the chain's valid bits, the overflow mark and the result strobe
//  the receiver cannot stall; results are never held back
module integer_group_sorter #(
    parameter int MAX_ITEMS = igs_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [igs_pkg::DATA_W-1:0]  value,
    input  logic                               group_end,
    output logic                               result_valid,
    output logic signed [igs_pkg::DATA_W-1:0]  sorted_value,
    output logic                               final_res,
    output logic                               overflow
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic [igs_pkg::DATA_W-1:0] sorted_value_reg;
    logic [igs_pkg::DATA_W-1:0] sorted_value_next;
    logic                       final_res_reg;
    logic                       final_res_next;
    logic                       overflow_reg;
    logic                       overflow_next;

    logic [igs_pkg::DATA_W-1:0] cell_val   [MAX_ITEMS];
    logic                       cell_valid [MAX_ITEMS];
    logic                       cell_shift [MAX_ITEMS];

    logic                       accept;
    logic                       full;
    igs_pkg::chain_ctrl_t       ctrl;

    assign accept      = start && (state_reg == ST_IDLE);
    assign full        = cell_valid[MAX_ITEMS-1];
    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = (state_reg == ST_DRAIN);

    // the chain of cells
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic [igs_pkg::DATA_W-1:0] prev_val;
        logic                       prev_valid;
        logic                       prev_shift;
        logic [igs_pkg::DATA_W-1:0] next_val;
        logic                       next_valid;

        if (i == 0)
        begin : g_head
            assign prev_val   = '0;
            assign prev_valid = 1'b0;
            assign prev_shift = 1'b0;
        end
        else
        begin : g_body
            assign prev_val   = cell_val[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_shift = cell_shift[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign next_val   = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_mid
            assign next_val   = cell_val[i+1];
            assign next_valid = cell_valid[i+1];
        end

        igs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_val    (value),
            .prev_val   (prev_val),
            .prev_valid (prev_valid),
            .prev_shift (prev_shift),
            .next_val   (next_val),
            .next_valid (next_valid),
            .val        (cell_val[i]),
            .valid      (cell_valid[i]),
            .shift      (cell_shift[i])
        );
    end

    // sequencer: collect a group, then drain it from the head cell
    always_comb
    begin
        state_next        = state_reg;
        ovf_next          = ovf_reg;
        result_valid_next = 1'b0;
        sorted_value_next = sorted_value_reg;
        final_res_next    = 1'b0;
        overflow_next     = overflow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ovf_next = ovf_reg || full;
                    if (group_end)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                result_valid_next = 1'b1;
                sorted_value_next = cell_val[0];
                final_res_next    = !cell_valid[1];
                overflow_next     = ovf_reg;
                if (!cell_valid[1])
                begin
                    state_next = ST_IDLE;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            final_res_reg    <= 1'b0;
            overflow_reg     <= 1'b0;
            sorted_value_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            final_res_reg    <= final_res_next;
            overflow_reg     <= overflow_next;
            sorted_value_reg <= sorted_value_next;
        end
    end

    assign busy         = (state_reg == ST_DRAIN);
    assign result_valid = result_valid_reg;
    assign sorted_value = $signed(sorted_value_reg);
    assign final_res    = final_res_reg;
    assign overflow     = overflow_reg;

endmodule

>>> src/igs_checker.sv
// port-level checker for the group sorter, bound to the top level
`include "assert_macros.svh"

module igs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          group_end,
    input logic                          result_valid,
    input logic                          final_res,
    input logic                          overflow
);

    // results of one group come out back to back
    `ASSERT_NEXT(a_group_contiguous, clk, rst_n, result_valid && !final_res, result_valid)

    // more results pending means the sorter is still busy
    `ASSERT_IMPLY(a_busy_while_pending, clk, rst_n, result_valid && !final_res, busy)

    // the last result frees the sorter
    `ASSERT_IMPLY(a_free_after_final, clk, rst_n, result_valid && final_res, !busy)

    // the overflow mark is the same on every result of a group
    `ASSERT_NEXT(a_overflow_steady, clk, rst_n, result_valid && !final_res,
                 overflow == $past(overflow))

    // a group's last beat starts the drain; the first result follows in the cycle after the drain starts
    `ASSERT_NEXT(a_end_starts_drain, clk, rst_n, start && !busy && group_end,
                 busy && !result_valid)

endmodule

bind integer_group_sorter igs_checker u_igs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .group_end    (group_end),
    .result_valid (result_valid),
    .final_res    (final_res),
    .overflow     (overflow)
);

>>> tb/group_sort_checker.sv
// checker for the group sorter: watches both channels, predicts sorted groups, compares results
`timescale 1ns / 1ps

module group_sort_checker #(
    parameter int MAX_ITEMS = igs_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [igs_pkg::DATA_W-1:0]  value,
    input  logic                               group_end,
    input  logic                               result_valid,
    input  logic signed [igs_pkg::DATA_W-1:0]  sorted_value,
    input  logic                               final_res,
    input  logic                               overflow,
    output int                                 mismatch_count,
    output int                                 results_owed
);

    typedef struct {
        logic signed [igs_pkg::DATA_W-1:0] val;
        logic                              last;
        logic                              ovf;
    } sorted_result_t;

    // predicted group store, kept ascending
    logic signed [igs_pkg::DATA_W-1:0] held_vals [MAX_ITEMS];
    int                                held_n;
    logic                              held_ovf;

    // sorted values still owed by the block, oldest first
    sorted_result_t owed_sorted [$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // insertion into the ascending store, drop when full
    task automatic insert_sorted(input logic signed [igs_pkg::DATA_W-1:0] v);
        int pos;
        if (held_n >= MAX_ITEMS)
        begin
            held_ovf = 1'b1;
            return;
        end
        pos = held_n;
        while (pos > 0 && v < held_vals[pos-1])
        begin
            held_vals[pos] = held_vals[pos-1];
            pos--;
        end
        held_vals[pos] = v;
        held_n++;
    endtask

    // one accepted input beat; group end releases the whole group
    task automatic take_beat(input logic signed [igs_pkg::DATA_W-1:0] v, input logic last);
        sorted_result_t r;
        insert_sorted(v);
        if (last)
        begin
            for (int k = 0; k < held_n; k++)
            begin
                r.val  = held_vals[k];
                r.last = (k + 1 == held_n);
                r.ovf  = held_ovf;
                owed_sorted.push_back(r);
            end
            held_n   = 0;
            held_ovf = 1'b0;
        end
    endtask

    // one result beat against the oldest owed value
    task automatic check_result();
        sorted_result_t r;
        if (owed_sorted.size() == 0)
        begin
            report_mismatch("unexpected result, sorted_value", sorted_value, 0);
            return;
        end
        r = owed_sorted.pop_front();
        if (sorted_value !== r.val)
            report_mismatch("sorted_value", sorted_value, r.val);
        if (final_res !== r.last)
            report_mismatch("final_res", final_res, r.last);
        if (overflow !== r.ovf)
            report_mismatch("overflow", overflow, r.ovf);
    endtask

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n   = 0;
            held_ovf = 1'b0;
            owed_sorted.delete();
            results_owed <= 0;
        end
        else
        begin
            if (result_valid)
                check_result();
            if (start && !busy)
                take_beat(value, group_end);
            results_owed <= owed_sorted.size();
        end
    end

endmodule

>>> tb/tb.sv
// testbench top: clock, reset, group stimulus and verdict for the group sorter
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ITEMS  = igs_pkg::MAX_ITEMS_DEF;
    localparam int RAND_ITEMS = 130;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic signed [igs_pkg::DATA_W-1:0]  value;
    logic                               group_end;
    logic                               result_valid;
    logic signed [igs_pkg::DATA_W-1:0]  sorted_value;
    logic                               final_res;
    logic                               overflow;

    int mismatch_count;
    int results_owed;
    int idle_pct;
    int items_sent;

    // values of the next group, in arrival order
    logic signed [igs_pkg::DATA_W-1:0] group_vals [$];

    integer_group_sorter #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .group_end    (group_end),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    group_sort_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .value          (value),
        .group_end      (group_end),
        .result_valid   (result_valid),
        .sorted_value   (sorted_value),
        .final_res      (final_res),
        .overflow       (overflow),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // random value: extremes, a narrow band for duplicates, or any pattern
    function automatic logic signed [igs_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       pick_value = 32'sh8000_0000;
            1:       pick_value = 32'sh7FFF_FFFF;
            2, 3, 4: pick_value = $signed($urandom_range(0, 16)) - 8;
            default: pick_value = $urandom;
        endcase
    endfunction

    // one input beat, held until the block takes it
    task automatic send_beat(input logic signed [igs_pkg::DATA_W-1:0] v, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        value     <= v;
        group_end <= last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send_group();
        for (int i = 0; i < group_vals.size(); i++)
            send_beat(group_vals[i], i == group_vals.size() - 1);
        group_vals.delete();
    endtask

    // hold the sender until every owed result has come out
    task automatic wait_results_done();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    // run limit
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        int grp;
        int grp_len;
        int first_item;

        rst_n     = 1'b0;
        start     = 1'b0;
        value     = '0;
        group_end = 1'b0;
        idle_pct  = 22;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-value groups at both extremes
        group_vals = '{32'sh8000_0000};
        send_group();
        group_vals = '{32'sh7FFF_FFFF};
        send_group();
        // extremes, zero, around zero, alternating bit patterns
        group_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                       32'sh5555_5555, 32'shAAAA_AAAA};
        send_group();
        // repeated values
        group_vals = '{3, 3, -7, 3, -7};
        send_group();
        // already ascending, then descending
        group_vals = '{-2, -1, 0, 1, 2};
        send_group();
        group_vals = '{9, 4, -4, -9};
        send_group();
        wait_results_done();

        // random groups over three idling phases
        first_item = items_sent;
        phase = 0;
        grp = 0;
        while (items_sent - first_item < RAND_ITEMS)
        begin
            if ((items_sent - first_item) / (RAND_ITEMS / 3) > phase)
            begin
                phase++;
                wait_results_done();
                idle_pct = (phase == 1) ? 67 : 0;
            end
            // mostly short groups; a few fill or overrun the store
            if (grp == 1)
                grp_len = MAX_ITEMS + $urandom_range(1, 5);
            else if (grp == 3)
                grp_len = MAX_ITEMS;
            else if ($urandom_range(0, 19) == 0)
                grp_len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
            else
                grp_len = $urandom_range(1, 8);
            for (int i = 0; i < grp_len; i++)
                group_vals.push_back(pick_value());
            send_group();
            grp++;
        end

        // drain and verdict
        wait_results_done();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
